### rtl/osp_pkg.sv
// Shared types, constants and the sine table builder for the open-loop sine PWM commutator.
// Used by osp_mul, the core, its checker and its testbench; depends on nothing else.
package osp_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ENTRIES   = 1024;
    localparam int SINE_ADDR_BITS = $clog2(SINE_ENTRIES);

    localparam logic [PHASE_BITS-1:0] THIRD_TURN =
        PHASE_BITS'(((65'd1 << PHASE_BITS) + 65'd1) / 65'd3);

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] HALF_TURN  = 64'd1 << 31;
    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
    localparam int          SINE_MAX   = 32767;

    localparam int MUL_A_BITS   = 32;
    localparam int MUL_B_BITS   = 16;
    localparam int MUL_DIGIT    = 4;
    localparam int MUL_STEPS    = MUL_B_BITS / MUL_DIGIT;
    localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [5:0]  RST_POLE_PAIRS   = 6'd7;
    localparam logic [23:0] RST_STEP_PER_RPM = 24'd3579;
    localparam logic [15:0] RST_AMPLITUDE    = 16'd9830;
    localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_POLE_PAIRS   = 3'd0,
        CFG_STEP_PER_RPM = 3'd1,
        CFG_AMPLITUDE    = 3'd2,
        CFG_PWM_PERIOD   = 3'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_M,
        ST_MUL_INC,
        ST_ADVANCE,
        ST_ADDR,
        ST_ROM,
        ST_MUL_AMP,
        ST_MUL_PER,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [MUL_A_BITS-1:0] a;
        logic [MUL_B_BITS-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [MUL_P_BITS-1:0] prod;
    } t_mul_rsp;

    typedef logic signed [15:0] t_sine_rom [SINE_ENTRIES];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] q;
        logic        neg;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            t   = 64'(k) << (32 - SINE_ADDR_BITS);
            neg = 1'b0;
            if (t >= HALF_TURN) begin
                neg = 1'b1;
                t   = t - HALF_TURN;
            end
            if (t > Q30_ONE) begin
                t = HALF_TURN - t;
            end
            x    = (t * TWO_PI_Q29) >> 31;
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            term = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
            term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
            term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
            term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
            term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
            s    = (x * term) >> 30;
            q    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (q > 64'(SINE_MAX)) begin
                q = 64'(SINE_MAX);
            end
            rom[k] = neg ? -16'(q) : 16'(q);
        end
        return rom;
    endfunction

endpackage

### rtl/osp_mul.sv
// Shared digit-serial multiplier: 32-bit multiplicand times 16-bit multiplier, one 4-bit digit
// per cycle, full 48-bit product. Depends on osp_pkg.
module osp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  osp_pkg::t_mul_req i_req,
    output osp_pkg::t_mul_rsp o_rsp
);
    import osp_pkg::*;

    logic                          r_busy;
    logic                          r_done;
    logic [MUL_CNT_BITS-1:0]       r_cnt;
    logic [MUL_A_BITS-1:0]         r_a;
    logic [MUL_A_BITS-1:0]         r_h;
    logic [MUL_B_BITS-1:0]         r_l;
    logic [MUL_A_BITS+MUL_DIGIT-1:0] step_sum;

    assign step_sum = (MUL_A_BITS+MUL_DIGIT)'(r_h)
                    + (MUL_A_BITS+MUL_DIGIT)'(r_a)
                    * (MUL_A_BITS+MUL_DIGIT)'(r_l[MUL_DIGIT-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_BITS'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_h <= step_sum[MUL_A_BITS+MUL_DIGIT-1:MUL_DIGIT];
            r_l <= {step_sum[MUL_DIGIT-1:0], r_l[MUL_B_BITS-1:MUL_DIGIT]};
        end else if (i_req.start) begin
            r_a <= i_req.a;
            r_h <= '0;
            r_l <= i_req.b;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_h, r_l};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start && !r_busy |=> r_busy)
        else $error("multiplier did not start");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiplier done without a busy cycle");
    a_busy_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ##(MUL_STEPS) r_done)
        else $error("multiplier step count wrong");

endmodule

### rtl/openloop_sine_pwm_commutator_core.sv
// Open-loop three-phase sine PWM commutator: phase accumulator, sine ROM and compare mapping.
// Depends on osp_pkg and osp_mul.
//
//   channel  signals                                        direction
//   input    i_in_valid, o_in_stall, i_enable, i_speed_rpm  in
//   output   o_out_valid, i_out_stall, o_compare_a/b/c      out
//   config   i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in
//
// An enabled item goes from its transfer to a loaded result through eight passes through
// the shared multiplier, each made of a start handshake and the digit steps. A disabled item
// goes straight to the done state. Reset is synchronous and restores the register defaults.
// The input stalls while an item is in work; a finished result waits in the output register,
// and a new item is taken while it is still stalled.
module openloop_sine_pwm_commutator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_enable,
    input  logic signed [15:0]                   i_speed_rpm,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [15:0]                          o_compare_a,
    output logic [15:0]                          o_compare_b,
    output logic [15:0]                          o_compare_c,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [osp_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [osp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import osp_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    t_state                    r_state;
    t_state                    n_state;
    logic [5:0]                r_pole_pairs;
    logic [23:0]               r_step_per_rpm;
    logic [15:0]               r_amplitude;
    logic [15:0]               r_pwm_period;
    logic [PHASE_BITS-1:0]     r_phase;
    logic [PHASE_BITS-1:0]     r_incr;
    logic                      r_was_enabled;
    logic [15:0]               r_speed;
    logic [31:0]               r_m;
    logic [1:0]                r_sel;
    logic [SINE_ADDR_BITS-1:0] r_addr;
    logic signed [15:0]        r_sine;
    logic [31:0]               r_level;
    logic                      r_lvl_zero;
    logic [15:0]               r_cmp_a;
    logic [15:0]               r_cmp_b;
    logic [15:0]               r_cmp_c;
    logic                      r_out_valid;
    logic [15:0]               r_out_a;
    logic [15:0]               r_out_b;
    logic [15:0]               r_out_c;

    t_mul_req                  mul_req;
    t_mul_rsp                  mul_rsp;
    logic                      in_xfer;
    logic                      out_free;
    logic [PHASE_BITS-1:0]     sel_phase;
    logic [15:0]               sine_abs;
    logic [31:0]               amp_p;
    logic [31:0]               corr;
    logic [16:0]               cmp_raw;
    logic [15:0]               cmp_val;

    osp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_pairs   <= RST_POLE_PAIRS;
            r_step_per_rpm <= RST_STEP_PER_RPM;
            r_amplitude    <= RST_AMPLITUDE;
            r_pwm_period   <= RST_PWM_PERIOD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLE_PAIRS:   r_pole_pairs   <= i_cfg_data[5:0];
                CFG_STEP_PER_RPM: r_step_per_rpm <= i_cfg_data[23:0];
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data[15:0];
                CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_sel)
            2'd1:    sel_phase = r_phase - THIRD_TURN;
            2'd2:    sel_phase = r_phase + THIRD_TURN;
            default: sel_phase = r_phase;
        endcase
    end

    assign sine_abs = r_sine[15] ? 16'(-r_sine) : 16'(r_sine);
    assign amp_p    = mul_rsp.prod[31:0];
    assign corr     = r_speed[15] ? {r_m[15:0], 16'd0} : 32'd0;
    assign cmp_raw  = mul_rsp.prod[47:31];
    assign cmp_val  = r_lvl_zero ? 16'd0
                    : (cmp_raw > {1'b0, r_pwm_period}) ? r_pwm_period : cmp_raw[15:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = i_enable ? ST_MUL_M : ST_DONE;
                end
            end
            ST_MUL_M: begin
                if (mul_rsp.done) n_state = ST_MUL_INC;
            end
            ST_MUL_INC: begin
                if (mul_rsp.done) n_state = ST_ADVANCE;
            end
            ST_ADVANCE: n_state = ST_ADDR;
            ST_ADDR:    n_state = ST_ROM;
            ST_ROM:     n_state = ST_MUL_AMP;
            ST_MUL_AMP: begin
                if (mul_rsp.done) n_state = ST_MUL_PER;
            end
            ST_MUL_PER: begin
                if (mul_rsp.done) n_state = (r_sel == 2'd2) ? ST_DONE : ST_ADDR;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        o_in_stall    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_MUL_M: begin
                mul_req.a = 32'(r_step_per_rpm);
                mul_req.b = 16'(r_pole_pairs);
            end
            ST_MUL_INC: begin
                mul_req.a = r_m;
                mul_req.b = r_speed;
            end
            ST_MUL_AMP: begin
                mul_req.a = 32'(r_amplitude);
                mul_req.b = sine_abs;
            end
            ST_MUL_PER: begin
                mul_req.a = r_level;
                mul_req.b = r_pwm_period;
            end
            default: ;
        endcase
        if (r_state == ST_MUL_M || r_state == ST_MUL_INC ||
            r_state == ST_MUL_AMP || r_state == ST_MUL_PER) begin
            mul_req.start = !mul_rsp.busy && !mul_rsp.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= '0;
            r_was_enabled <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_xfer) begin
                r_was_enabled <= i_enable;
                if (i_enable && !r_was_enabled) begin
                    r_phase <= '0;
                end
            end
            if (r_state == ST_ADVANCE) begin
                r_phase <= r_phase + r_incr;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_speed <= i_speed_rpm;
                r_sel   <= 2'd0;
                r_cmp_a <= {1'b0, r_pwm_period[15:1]};
                r_cmp_b <= {1'b0, r_pwm_period[15:1]};
                r_cmp_c <= {1'b0, r_pwm_period[15:1]};
            end
            ST_MUL_M: begin
                if (mul_rsp.done) r_m <= mul_rsp.prod[31:0];
            end
            ST_MUL_INC: begin
                if (mul_rsp.done) r_incr <= PHASE_BITS'(mul_rsp.prod[31:0] - corr);
            end
            ST_ADDR: begin
                r_addr <= sel_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
            end
            ST_ROM: begin
                r_sine <= SINE_ROM[r_addr];
            end
            ST_MUL_AMP: begin
                if (mul_rsp.done) begin
                    if (r_sine[15]) begin
                        r_lvl_zero <= (amp_p >= Q30_ONE[31:0]);
                        r_level    <= Q30_ONE[31:0] - amp_p;
                    end else begin
                        r_lvl_zero <= 1'b0;
                        r_level    <= Q30_ONE[31:0] + amp_p;
                    end
                end
            end
            ST_MUL_PER: begin
                if (mul_rsp.done) begin
                    unique case (r_sel)
                        2'd0:    r_cmp_a <= cmp_val;
                        2'd1:    r_cmp_b <= cmp_val;
                        default: r_cmp_c <= cmp_val;
                    endcase
                    r_sel <= r_sel + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_a <= r_cmp_a;
                    r_out_b <= r_cmp_b;
                    r_out_c <= r_cmp_c;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_compare_a = r_out_a;
    assign o_compare_b = r_out_b;
    assign o_compare_c = r_out_c;

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result register loaded outside the done state");
    a_advance_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADVANCE |-> r_was_enabled)
        else $error("phase advanced while disabled");
    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier restarted while busy");
    a_compare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compare_a <= r_pwm_period) && (o_compare_b <= r_pwm_period)
                        && (o_compare_c <= r_pwm_period))
        else $error("compare above the PWM period");

endmodule

### sim/openloop_sine_pwm_commutator_checker.sv
// Checker for the open-loop sine PWM commutator: watches the config, input and output channels.
// Predicts the three compares of every accepted tick and compares them with the block's results.
// Depends on osp_pkg for the port widths and the register index names.
module openloop_sine_pwm_commutator_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               i_enable,
    input  logic signed [15:0]                 i_speed_rpm,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic [15:0]                        o_compare_a,
    input  logic [15:0]                        o_compare_b,
    input  logic [15:0]                        o_compare_c,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic [osp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [osp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                 o_fault_count,
    output int                                 o_pending
);
    import osp_pkg::*;

    localparam logic [31:0] ONE_THIRD_TURN = 32'd1431655765;
    localparam logic [63:0] UNIT_Q30       = 64'd1 << 30;
    localparam logic [63:0] HALF_TURN_Q32  = 64'd1 << 31;
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_compare_set;

    logic signed [15:0] sine_lut [1024];
    t_compare_set       compares_due [$];

    logic [5:0]  pole_pairs_q;
    logic [23:0] step_q;
    logic [15:0] amplitude_q;
    logic [15:0] period_q;
    logic [31:0] elec_phase;
    logic        running;
    int          fault_count = 0;

    function automatic logic signed [15:0] sine_q15(int unsigned k);
        logic [63:0] frac;
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] series;
        logic [63:0] prod;
        logic [63:0] mag;
        logic        lower_half;
        frac       = 64'(k) << 22;
        lower_half = 1'b0;
        if (frac >= HALF_TURN_Q32) begin
            lower_half = 1'b1;
            frac       = frac - HALF_TURN_Q32;
        end
        if (frac > UNIT_Q30) begin
            frac = HALF_TURN_Q32 - frac;
        end
        ang    = (frac * 64'd3373259426) >> 31;
        ang2   = (ang * ang) >> 30;
        series = UNIT_Q30;
        series = UNIT_Q30 - ((ang2 * series) >> 30) / 64'd110;
        series = UNIT_Q30 - ((ang2 * series) >> 30) / 64'd72;
        series = UNIT_Q30 - ((ang2 * series) >> 30) / 64'd42;
        series = UNIT_Q30 - ((ang2 * series) >> 30) / 64'd20;
        series = UNIT_Q30 - ((ang2 * series) >> 30) / 64'd6;
        prod   = (ang * series) >> 30;
        mag    = (prod * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return lower_half ? -16'(mag) : 16'(mag);
    endfunction

    function automatic logic [15:0] compare_at(logic [31:0] phase);
        longint      level;
        logic [63:0] scaled;
        level = longint'(UNIT_Q30) + longint'(amplitude_q) * longint'(sine_lut[phase[31:22]]);
        if (level <= 0) begin
            return 16'd0;
        end
        scaled = (64'(period_q) * unsigned'(level)) >> 31;
        if (scaled > 64'(period_q)) begin
            scaled = 64'(period_q);
        end
        return scaled[15:0];
    endfunction

    function automatic t_compare_set next_compares(logic enable, logic signed [15:0] speed);
        t_compare_set res;
        logic [31:0]  incr;
        if (!enable) begin
            running = 1'b0;
            res.a   = period_q >> 1;
            res.b   = period_q >> 1;
            res.c   = period_q >> 1;
            return res;
        end
        if (!running) begin
            elec_phase = '0;
        end
        running    = 1'b1;
        incr       = 32'(longint'(speed) * longint'(pole_pairs_q) * longint'(step_q));
        elec_phase = elec_phase + incr;
        res.a      = compare_at(elec_phase);
        res.b      = compare_at(elec_phase - ONE_THIRD_TURN);
        res.c      = compare_at(elec_phase + ONE_THIRD_TURN);
        return res;
    endfunction

    initial begin
        for (int k = 0; k < 1024; k++) begin
            sine_lut[k] = sine_q15(k);
        end
    end

    always @(posedge i_clk) begin
        t_compare_set got;
        t_compare_set want;
        if (!i_rst_n) begin
            pole_pairs_q = 6'd7;
            step_q       = 24'd3579;
            amplitude_q  = 16'd9830;
            period_q     = 16'd1000;
            elec_phase   = '0;
            running      = 1'b0;
            compares_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_POLE_PAIRS:   pole_pairs_q = i_cfg_data[5:0];
                    CFG_STEP_PER_RPM: step_q       = i_cfg_data[23:0];
                    CFG_AMPLITUDE:    amplitude_q  = i_cfg_data[15:0];
                    CFG_PWM_PERIOD:   period_q     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_compare_a, o_compare_b, o_compare_c};
                if (compares_due.size() == 0) begin
                    if (fault_count < REPORT_LIMIT) begin
                        $display("unexpected compare transfer: a=%0d b=%0d c=%0d",
                                 got.a, got.b, got.c);
                    end
                    fault_count++;
                end else begin
                    want = compares_due.pop_front();
                    if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
                        if (fault_count < REPORT_LIMIT) begin
                            $display("compare mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                                     want.a, want.b, want.c, got.a, got.b, got.c);
                        end
                        fault_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                compares_due.push_back(next_compares(i_enable, i_speed_rpm));
            end
        end
        o_pending     = compares_due.size();
        o_fault_count = fault_count;
    end

endmodule

### sim/openloop_sine_pwm_commutator_core_tb.sv
// Testbench top for openloop_sine_pwm_commutator_core: clock, reset, stimulus and verdict.
// Depends on osp_pkg, the core and openloop_sine_pwm_commutator_checker.
module openloop_sine_pwm_commutator_core_tb;
    import osp_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 60;
    localparam int SEGMENTS         = 6;
    localparam int SEGMENT_TICKS    = 75;
    localparam int CFG_FIRST_UNUSED = int'(CFG_PWM_PERIOD) + 1;
    localparam int CFG_LAST_INDEX   = (1 << CFG_INDEX_BITS) - 1;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic                      i_enable    = 1'b0;
    logic signed [15:0]        i_speed_rpm = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [15:0]               o_compare_a;
    logic [15:0]               o_compare_b;
    logic [15:0]               o_compare_c;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    int                        o_fault_count;
    int                        o_pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;

    openloop_sine_pwm_commutator_core dut (.*);

    openloop_sine_pwm_commutator_checker checker_i (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_tick(input logic en, input int spd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_enable    = en;
        i_speed_rpm = 16'(spd);
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (o_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_setting(input logic [23:0] pp, input logic [23:0] step,
                                 input logic [23:0] amp, input logic [23:0] period);
        write_reg(CFG_POLE_PAIRS, pp);
        write_reg(CFG_STEP_PER_RPM, step);
        write_reg(CFG_AMPLITUDE, amp);
        write_reg(CFG_PWM_PERIOD, period);
    endtask

    function automatic logic [23:0] pick_value(int unsigned lo, int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return 24'(lo);
        end else if (roll < 20) begin
            return 24'(hi);
        end else if (roll < 25) begin
            return 24'($urandom);
        end
        return 24'($urandom_range(hi, lo));
    endfunction

    task automatic send_random_tick();
        int roll;
        int spd;
        roll = $urandom_range(99);
        if (roll < 70) begin
            spd = int'($urandom_range(60000)) - 30000;
        end else if (roll < 85) begin
            spd = int'($urandom_range(100)) - 50;
        end else begin
            spd = int'($urandom_range(65535));
        end
        send_tick($urandom_range(99) >= 6, spd);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_tick(1'b0, 0);
        send_tick(1'b1, 30000);
        send_tick(1'b1, 30000);
        send_tick(1'b1, -30000);
        send_tick(1'b0, 123);
        send_tick(1'b1, 0);
        send_tick(1'b1, 32767);
        send_tick(1'b1, -32768);
        send_tick(1'b1, 1);
        send_tick(1'b1, -1);
        drain();
        write_setting(24'h00003F, 24'hFFFFFF, 24'h00FFFF, 24'h00FFFF);
        send_tick(1'b1, 30000);
        send_tick(1'b1, -30000);
        send_tick(1'b1, 12345);
        send_tick(1'b0, 0);
        drain();
        write_setting(24'hFFFFC0, 24'd12345, 24'd32768, 24'd0);
        send_tick(1'b1, 1000);
        send_tick(1'b0, 5);
        send_tick(1'b1, 2000);
        drain();
        write_setting(24'd1, 24'd0, 24'd0, 24'd1);
        send_tick(1'b1, 30000);
        send_tick(1'b1, -1);
        send_tick(1'b0, 0);
        drain();
        for (int idx = CFG_FIRST_UNUSED; idx <= CFG_LAST_INDEX; idx++) begin
            write_reg(CFG_INDEX_BITS'(idx), 24'($urandom));
        end
        write_setting(24'd7, 24'd3579, 24'd9830, 24'd1000);
        send_tick(1'b1, 100);
        send_tick(1'b1, 200);

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 11 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                drain();
                if (seg == 0) begin
                    write_setting(24'd63, 24'hFFFFFF, 24'd32768, 24'd65535);
                end else if (seg == 1) begin
                    write_setting(24'd1, 24'd0, 24'd0, 24'd1);
                end else begin
                    write_setting(pick_value(1, 63), pick_value(0, 24'hFFFFFF),
                                  pick_value(0, 32768), pick_value(1, 65535));
                    if ($urandom_range(9) == 0) begin
                        write_reg(CFG_INDEX_BITS'($urandom_range(CFG_LAST_INDEX,
                                                                 CFG_FIRST_UNUSED)),
                                  24'($urandom));
                    end
                end
                for (int n = 0; n < SEGMENT_TICKS; n++) begin
                    if (seg == 2 && n == 10 && phase != 1) begin
                        hold_request = HOLD_OFF_CYCLES;
                    end
                    if (seg == 3 && n == 40) begin
                        drain();
                    end
                    send_random_tick();
                end
            end
        end

        i_in_valid = 1'b0;
        while (o_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (o_fault_count == 0 && o_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
